/* rtl/iir_filter_direct_form_defines.svh */
// ----------------------------------------------------------------------------
// IIR filter assertion macros
// Shared wrappers for the concurrent checks of the IIR filter RTL.
// ----------------------------------------------------------------------------
`ifndef IIR_FILTER_DIRECT_FORM_DEFINES_SVH
`define IIR_FILTER_DIRECT_FORM_DEFINES_SVH

// Check sampled on clk, off while rst is high.
`define IIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on clk, active during reset as well.
`define IIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/iir_pkg.sv */
// ----------------------------------------------------------------------------
// IIR filter package
// Widths, register defaults, register indexes and controller states.
// ----------------------------------------------------------------------------
package iir_pkg;

  localparam int TAPS      = 8;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 15;
  localparam int TAPS_W    = 4;

  localparam int ADDR_W    = $clog2(TAPS);
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CNT_W     = $clog2(TAPS);
  localparam int SUM_W     = SAMPLE_W + $clog2(TAPS);
  localparam int PROD_W    = GAIN_W + SUM_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int YFULL_W   = ACC_W - GAIN_FRAC;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic signed [GAIN_W-1:0] FF_GAIN_RST = GAIN_W'(3277);
  localparam logic signed [GAIN_W-1:0] FB_GAIN_RST = GAIN_W'(16384);
  localparam logic [TAPS_W-1:0]        TAPS_RST    = TAPS_W'(TAPS);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_GAIN     = 2'd0,
    REG_FB_GAIN     = 2'd1,
    REG_TAPS_IN_USE = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

/* rtl/iir_filter_direct_form.sv */
// ----------------------------------------------------------------------------
// IIR filter, direct form I
// Shared-coefficient IIR filter on a stream of signed Q1.15 samples.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tdata[15:0] is the sample, s_tuser flags the start of a
// stream (clear both histories before filtering this sample). Output stream
// m_*: m_tdata[15:0] is the filtered, saturated sample, m_tuser is set when
// the result was clipped. One result leaves for every sample taken in.
// Configuration: cfg_index/cfg_data with cfg_valid/cfg_ready; index 0 is the
// feed-forward gain, 1 the feedback gain, 2 the tap count. Write only while
// the filter is idle; the port is always ready.
// Both histories sit in small memories with one read and one write port each,
// used as ring buffers. From its transfer to its result a sample passes, for
// K of 2 to 8 (K = effective tap count), through one read per past tap of the
// history memories and a drain of the reads, then multiply, subtract and
// round/saturate. A single tap skips the reads. The next sample is taken only
// once the result is written and the filter is back in idle, so it does not
// take a new sample while one is in process. A finished result waits in the
// output register; while the receiver stalls, the filter takes one more sample
// and holds it at the final stage. Reset clears the histories, restores the
// default gains and tap count, and leaves both streams empty.
// ----------------------------------------------------------------------------
`include "iir_filter_direct_form_defines.svh"

module iir_filter_direct_form (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [iir_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample_in
  input  logic                              s_tuser,   // [0] start_of_stream
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [iir_pkg::SAMPLE_W-1:0]      m_tdata,   // [15:0] sample_out
  output logic                              m_tuser,   // [0] saturated
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [iir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iir_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SW = iir_pkg::SAMPLE_W;
  localparam int AW = iir_pkg::ADDR_W;

  // configuration
  logic signed [iir_pkg::GAIN_W-1:0] ff_gain;
  logic signed [iir_pkg::GAIN_W-1:0] fb_gain;
  logic [iir_pkg::TAPS_W-1:0]        taps_in_use;

  // control
  iir_pkg::state_t                   state;
  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     rd_addr;
  logic [iir_pkg::CNT_W-1:0]         cnt;
  logic [iir_pkg::CNT_W-1:0]         nreads;
  logic                              rd_pend;
  logic                              rd_ok;
  logic [iir_pkg::MEM_DEPTH-1:0]     vld;

  // datapath
  logic signed [SW-1:0]              x;
  logic signed [iir_pkg::SUM_W-1:0]  sum_in;
  logic signed [iir_pkg::SUM_W-1:0]  sum_out;
  logic signed [iir_pkg::PROD_W-1:0] p_ff;
  logic signed [iir_pkg::PROD_W-1:0] p_fb;
  logic signed [iir_pkg::ACC_W-1:0]  acc;

  // history memories
  logic [SW-1:0] mem_in  [iir_pkg::MEM_DEPTH];
  logic [SW-1:0] mem_out [iir_pkg::MEM_DEPTH];
  logic [SW-1:0] rd_in;
  logic [SW-1:0] rd_out;

  logic                              in_xfer;
  logic                              out_free;
  logic                              rd_en;
  logic                              wr_en;
  logic [iir_pkg::TAPS_W-1:0]        k_eff;
  logic [iir_pkg::ACC_W-1:0]         rnd;
  logic [iir_pkg::YFULL_W-1:0]       y_full;
  logic                              y_sat;
  logic [SW-1:0]                     y;
  logic signed [iir_pkg::SUM_W-1:0]  add_in;
  logic signed [iir_pkg::SUM_W-1:0]  add_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == iir_pkg::ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign rd_en     = (state == iir_pkg::ST_READ) && (cnt < nreads);
  assign wr_en     = (state == iir_pkg::ST_FIN) && out_free;

  // clamp the tap count to 1..TAPS
  always_comb begin
    if (taps_in_use == '0) begin
      k_eff = iir_pkg::TAPS_W'(1);
    end else if (taps_in_use > iir_pkg::TAPS_W'(iir_pkg::TAPS)) begin
      k_eff = iir_pkg::TAPS_W'(iir_pkg::TAPS);
    end else begin
      k_eff = taps_in_use;
    end
  end

  // entries never written since the last clear read as zero
  assign add_in  = rd_ok ? {{(iir_pkg::SUM_W-SW){rd_in[SW-1]}}, rd_in} : '0;
  assign add_out = rd_ok ? {{(iir_pkg::SUM_W-SW){rd_out[SW-1]}}, rd_out} : '0;

  // round half up, then clip to the sample range
  assign rnd    = acc + (iir_pkg::ACC_W'(1) << (iir_pkg::GAIN_FRAC - 1));
  assign y_full = rnd[iir_pkg::ACC_W-1:iir_pkg::GAIN_FRAC];
  assign y_sat  = !((&y_full[iir_pkg::YFULL_W-1:SW-1]) ||
                    !(|y_full[iir_pkg::YFULL_W-1:SW-1]));

  always_comb begin
    if (!y_sat) begin
      y = y_full[SW-1:0];
    end else if (y_full[iir_pkg::YFULL_W-1]) begin
      y = iir_pkg::SAMPLE_MIN;
    end else begin
      y = iir_pkg::SAMPLE_MAX;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_gain     <= iir_pkg::FF_GAIN_RST;
      fb_gain     <= iir_pkg::FB_GAIN_RST;
      taps_in_use <= iir_pkg::TAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (iir_pkg::cfg_reg_t'(cfg_index))
        iir_pkg::REG_FF_GAIN:     ff_gain     <= cfg_data[iir_pkg::GAIN_W-1:0];
        iir_pkg::REG_FB_GAIN:     fb_gain     <= cfg_data[iir_pkg::GAIN_W-1:0];
        iir_pkg::REG_TAPS_IN_USE: taps_in_use <= cfg_data[iir_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // history memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_in  <= mem_in[rd_addr];
      rd_out <= mem_out[rd_addr];
    end
    if (wr_en) begin
      mem_in[wp]  <= x;
      mem_out[wp] <= y;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= iir_pkg::ST_IDLE;
      wp      <= '0;
      vld     <= '0;
      rd_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        iir_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (s_tuser) begin
              vld <= '0;
            end
            state   <= iir_pkg::ST_READ;
            rd_addr <= wp - AW'(1);
            cnt     <= '0;
            nreads  <= iir_pkg::CNT_W'(k_eff - iir_pkg::TAPS_W'(1));
            rd_pend <= 1'b0;
          end
        end
        iir_pkg::ST_READ: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            rd_ok   <= vld[rd_addr];
            rd_addr <= rd_addr - AW'(1);
            cnt     <= cnt + iir_pkg::CNT_W'(1);
          end else if (!rd_pend) begin
            state <= iir_pkg::ST_MUL;
          end
        end
        iir_pkg::ST_MUL: begin
          state <= iir_pkg::ST_SUM;
        end
        iir_pkg::ST_SUM: begin
          state <= iir_pkg::ST_FIN;
        end
        iir_pkg::ST_FIN: begin
          if (out_free) begin
            vld[wp]  <= 1'b1;
            wp       <= wp + AW'(1);
            state    <= iir_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= iir_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x       <= s_tdata;
      sum_in  <= {{(iir_pkg::SUM_W-SW){s_tdata[SW-1]}}, s_tdata};
      sum_out <= '0;
    end else if ((state == iir_pkg::ST_READ) && rd_pend) begin
      sum_in  <= sum_in + add_in;
      sum_out <= sum_out + add_out;
    end
    if (state == iir_pkg::ST_MUL) begin
      p_ff <= ff_gain * sum_in;
      p_fb <= fb_gain * sum_out;
    end
    if (state == iir_pkg::ST_SUM) begin
      acc <= {p_ff[iir_pkg::PROD_W-1], p_ff} - {p_fb[iir_pkg::PROD_W-1], p_fb};
    end
    if (wr_en) begin
      m_tdata <= y;
      m_tuser <= y_sat;
    end
  end

  `IIR_ASSERT(a_xfer_starts_read, in_xfer |=> (state == iir_pkg::ST_READ),
              "sample transfer did not start the history read")
  `IIR_ASSERT(a_read_bound, (state == iir_pkg::ST_READ) |-> (cnt <= nreads),
              "history read ran past the tap count")
  `IIR_ASSERT(a_write_loads_out, wr_en |=> m_tvalid,
              "history write without a result in the output register")
  `IIR_ASSERT(a_wp_step, wr_en |=> (wp == AW'($past(wp) + AW'(1))),
              "write pointer did not advance by one")
  `IIR_ASSERT(a_sat_value, (m_tvalid && m_tuser) |->
              ((m_tdata == iir_pkg::SAMPLE_MAX) || (m_tdata == iir_pkg::SAMPLE_MIN)),
              "saturation flag on an unclipped value")
  `IIR_ASSERT_ALWAYS(a_rst_idle, rst |=> (!m_tvalid && s_tready),
                     "filter not idle after reset")

endmodule

/* tb/tb_iir_filter_direct_form.sv */
// ----------------------------------------------------------------------------
// IIR filter testbench
// Streams Q1.15 samples through the direct form I filter under several gain
// and tap-count settings. Each transfer in is run through a local model of the
// filter and the expected output is queued. Each output transfer is checked
// against the oldest queued value. Both streams stall at random.
// ----------------------------------------------------------------------------
module tb_iir_filter_direct_form;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_LEN    = iir_pkg::TAPS - 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [iir_pkg::SAMPLE_W-1:0] sample;
    logic                         clipped;
  } filt_out_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [iir_pkg::SAMPLE_W-1:0]  s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b1;
  logic [iir_pkg::SAMPLE_W-1:0]  m_tdata;
  logic                          m_tuser;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [iir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [iir_pkg::CFG_W-1:0]     cfg_data  = '0;

  // filter model state
  logic signed [iir_pkg::GAIN_W-1:0]   ff_gain_reg = iir_pkg::FF_GAIN_RST;
  logic signed [iir_pkg::GAIN_W-1:0]   fb_gain_reg = iir_pkg::FB_GAIN_RST;
  logic [iir_pkg::TAPS_W-1:0]          taps_reg    = iir_pkg::TAPS_RST;
  logic signed [iir_pkg::SAMPLE_W-1:0] in_hist  [HIST_LEN] = '{default: '0};
  logic signed [iir_pkg::SAMPLE_W-1:0] out_hist [HIST_LEN] = '{default: '0};

  filt_out_t pending_out[$];
  bit        idle_on        = 1'b1;
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  iir_filter_direct_form u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Filter one sample and advance both histories.
  function automatic filt_out_t filter_sample(logic signed [iir_pkg::SAMPLE_W-1:0] x,
                                              logic clear);
    filt_out_t res;
    longint    sum_in;
    longint    sum_out;
    longint    acc;
    longint    y;
    longint    smax;
    int        k;
    smax = (longint'(1) << (iir_pkg::SAMPLE_W - 1)) - 1;
    if (clear) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        in_hist[i]  = '0;
        out_hist[i] = '0;
      end
    end
    k = (taps_reg == 0) ? 1 : (taps_reg > iir_pkg::TAPS) ? iir_pkg::TAPS : int'(taps_reg);
    sum_in  = x;
    sum_out = 0;
    for (int i = 0; i < k - 1; i++) begin
      sum_in  += in_hist[i];
      sum_out += out_hist[i];
    end
    acc = ff_gain_reg * sum_in - fb_gain_reg * sum_out;
    // round half up, then floor
    y = (acc + (longint'(1) << (iir_pkg::GAIN_FRAC - 1))) >>> iir_pkg::GAIN_FRAC;
    res.clipped = 1'b0;
    if (y > smax) begin
      y = smax;
      res.clipped = 1'b1;
    end else if (y < -smax - 1) begin
      y = -smax - 1;
      res.clipped = 1'b1;
    end
    for (int i = HIST_LEN - 1; i > 0; i--) begin
      in_hist[i]  = in_hist[i-1];
      out_hist[i] = out_hist[i-1];
    end
    in_hist[0]  = x;
    out_hist[0] = y[iir_pkg::SAMPLE_W-1:0];
    res.sample  = y[iir_pkg::SAMPLE_W-1:0];
    return res;
  endfunction

  function automatic logic [iir_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? iir_pkg::SAMPLE_MAX : iir_pkg::SAMPLE_MIN;
      1, 2:    return iir_pkg::SAMPLE_W'($urandom_range(0, 200) - 100);
      default: return iir_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [iir_pkg::SAMPLE_W-1:0] x, logic sos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tuser  <= sos;
    do @(posedge clk); while (!s_tready);
    pending_out.push_back(filter_sample(x, sos));
  endtask

  // Drop the input stream and hold until every queued output has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
  endtask

  task automatic cfg_xfer(iir_pkg::cfg_reg_t idx, logic [iir_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      iir_pkg::REG_FF_GAIN:     ff_gain_reg = val;
      iir_pkg::REG_FB_GAIN:     fb_gain_reg = val;
      iir_pkg::REG_TAPS_IN_USE: taps_reg    = val[iir_pkg::TAPS_W-1:0];
      default: ;
    endcase
  endtask

  // The unused index is poked too; it must change nothing.
  task automatic apply_config(logic [iir_pkg::CFG_W-1:0] ff, logic [iir_pkg::CFG_W-1:0] fb,
                              logic [iir_pkg::CFG_W-1:0] taps_word);
    wait_drained();
    cfg_xfer(iir_pkg::REG_UNUSED, iir_pkg::CFG_W'($urandom));
    cfg_xfer(iir_pkg::REG_FF_GAIN, ff);
    cfg_xfer(iir_pkg::REG_FB_GAIN, fb);
    cfg_xfer(iir_pkg::REG_TAPS_IN_USE, taps_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_stream(int count, logic [iir_pkg::CFG_W-1:0] ff,
                            logic [iir_pkg::CFG_W-1:0] fb,
                            logic [iir_pkg::CFG_W-1:0] taps_word, bit with_pause);
    apply_config(ff, fb, taps_word);
    for (int n = 0; n < count; n++) begin
      if (with_pause && n == count / 2) begin
        wait_drained();
      end
      send_sample(random_sample(), $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(iir_pkg::SAMPLE_MAX, 1'b1);
    send_sample(iir_pkg::SAMPLE_MAX, 1'b0);
    send_sample(iir_pkg::SAMPLE_MIN, 1'b0);
    send_sample(iir_pkg::SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b0);
  endtask

  task automatic test_saturation();
    // full positive gain with a negative feedback gain drives the output to the rails
    apply_config(16'h7FFF, 16'h8000, 16'd8);
    send_sample(iir_pkg::SAMPLE_MAX, 1'b1);
    repeat (3) send_sample(iir_pkg::SAMPLE_MAX, 1'b0);
    repeat (2) send_sample(iir_pkg::SAMPLE_MIN, 1'b0);
    apply_config(16'h8000, 16'h7FFF, 16'd8);
    send_sample(iir_pkg::SAMPLE_MAX, 1'b1);
    send_sample(iir_pkg::SAMPLE_MIN, 1'b0);
    send_sample(iir_pkg::SAMPLE_MAX, 1'b0);
  endtask

  task automatic test_tap_count_limits();
    // zero taps acts as one; half gain exposes rounding ties
    apply_config(16'd16384, 16'd16384, 16'hFFF0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd3, 1'b0);
    // counts above the filter length act as full length
    apply_config(16'd16384, 16'd8192, 16'hA5CF);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd3000, 1'b0);
    send_sample(iir_pkg::SAMPLE_MAX, 1'b0);
    apply_config(iir_pkg::FF_GAIN_RST, iir_pkg::FB_GAIN_RST, 16'd9);
    send_sample(16'sd12345, 1'b0);
    send_sample(iir_pkg::SAMPLE_MIN, 1'b0);
    send_sample(16'sd7, 1'b1);
  endtask

  task automatic test_random_streams();
    run_stream(125, iir_pkg::FF_GAIN_RST, iir_pkg::FB_GAIN_RST,
               iir_pkg::CFG_W'(iir_pkg::TAPS_RST), 1'b0);
    run_stream(125, iir_pkg::CFG_W'($urandom), iir_pkg::CFG_W'($urandom),
               iir_pkg::CFG_W'($urandom), 1'b0);
    run_stream(125, 16'h8000, 16'h7FFF, 16'd8, 1'b0);
    run_stream(125, 16'h7FFF, 16'h8000, 16'd2, 1'b0);
    run_stream(125, iir_pkg::CFG_W'($urandom_range(0, 8192) - 4096),
               iir_pkg::CFG_W'($urandom_range(0, 8192) - 4096),
               iir_pkg::CFG_W'($urandom_range(1, iir_pkg::TAPS)), 1'b1);
    idle_on = 1'b0;
    run_stream(125, iir_pkg::CFG_W'($urandom), iir_pkg::CFG_W'($urandom),
               iir_pkg::CFG_W'($urandom), 1'b0);
  endtask

  // output side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_outputs
    filt_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_out.size() == 0) begin
        $error("output transfer with no sample pending: sample_out=%0d saturated=%0b",
               $signed(m_tdata), m_tuser);
        mismatch_count++;
      end else begin
        want = pending_out.pop_front();
        if (m_tdata !== want.sample) begin
          $error("sample_out mismatch: expected %0d, got %0d",
                 $signed(want.sample), $signed(m_tdata));
          mismatch_count++;
        end
        if (m_tuser !== want.clipped) begin
          $error("saturated mismatch: expected %0b, got %0b", want.clipped, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_saturation();
    test_tap_count_limits();
    test_random_streams();
    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
